FILE: design/fraction_reduce_defines.svh
// Assertion macros shared by the fraction reduction block.
`ifndef FRACTION_REDUCE_DEFINES_SVH
`define FRACTION_REDUCE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fraction_reduce check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fraction_reduce check failed");

`endif

FILE: design/frd_pkg.sv
// Shared widths, types and helpers for the fraction reduction block.
package frd_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  // Status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^(WIDTH-1)
  function automatic logic [WIDTH-1:0] magnitude(input logic [WIDTH-1:0] v);
    logic [WIDTH-1:0] res;
    res = v[WIDTH-1] ? ((~v) + WIDTH'(1)) : v;
    return res;
  endfunction

endpackage

FILE: design/frd_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module frd_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [frd_pkg::WIDTH-1:0]    dividend,
  input  logic [frd_pkg::WIDTH-1:0]    divisor,
  output logic [frd_pkg::WIDTH-1:0]    quotient,
  output logic [frd_pkg::WIDTH-1:0]    remainder,
  output frd_pkg::div_stat_t           stat
);

  logic [frd_pkg::WIDTH-1:0] quo;
  logic [frd_pkg::WIDTH-1:0] rem;
  logic [frd_pkg::WIDTH-1:0] dsr;
  logic [frd_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;

  logic [frd_pkg::WIDTH:0]   shifted;
  logic [frd_pkg::WIDTH:0]   diff;
  logic                      qbit;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[frd_pkg::WIDTH-1]};
    diff    = shifted - {1'b0, dsr};
    qbit    = ~diff[frd_pkg::WIDTH];
  end

  // Control: run WIDTH steps after each start, pulse done on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + frd_pkg::CNT_W'(1);
        if (cnt == frd_pkg::CNT_W'(frd_pkg::WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[frd_pkg::WIDTH-2:0], qbit};
      rem <= qbit ? diff[frd_pkg::WIDTH-1:0] : shifted[frd_pkg::WIDTH-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

endmodule

FILE: design/fraction_reduce.sv
// One shared bit-serial divider serves every Euclid remainder step and both exact
// divisions; a zero denominator skips them and goes straight to the result.
// The block takes no new item until the last one is done: in_stall stays high from
// accept until the result is registered. Synchronous active-high reset clears the
// sequencer, the divider control and the output valid; no other state.
module fraction_reduce (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [frd_pkg::WIDTH-1:0]  numerator,
  input  logic signed [frd_pkg::WIDTH-1:0]  denominator,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [frd_pkg::WIDTH-1:0]  reduced_numerator,
  output logic signed [frd_pkg::WIDTH-1:0]  reduced_denominator,
  output logic                              status
);

  `include "fraction_reduce_defines.svh"

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EUC      = 3'd1;
  localparam logic [2:0] S_EUC_WAIT = 3'd2;
  localparam logic [2:0] S_QN       = 3'd3;
  localparam logic [2:0] S_QN_WAIT  = 3'd4;
  localparam logic [2:0] S_QD       = 3'd5;
  localparam logic [2:0] S_QD_WAIT  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]                state;
  logic [frd_pkg::WIDTH-1:0] a;
  logic [frd_pkg::WIDTH-1:0] b;
  logic [frd_pkg::WIDTH-1:0] nm;
  logic [frd_pkg::WIDTH-1:0] dm;
  logic [frd_pkg::WIDTH-1:0] qn;
  logic [frd_pkg::WIDTH-1:0] num_raw;
  logic                      neg;
  logic                      inv;

  logic                      in_accept;
  logic                      out_free;
  logic                      div_start;
  logic [frd_pkg::WIDTH-1:0] div_dividend;
  logic [frd_pkg::WIDTH-1:0] div_divisor;
  logic [frd_pkg::WIDTH-1:0] div_quo;
  logic [frd_pkg::WIDTH-1:0] div_rem;
  frd_pkg::div_stat_t        div_stat;
  logic [frd_pkg::WIDTH-1:0] signed_qn;
  logic                      div_waiting;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;

  // Route operands to the shared divider: remainder steps, then the two exact divisions
  always_comb begin
    div_start    = ((state == S_EUC) && (b != '0)) || (state == S_QN) || (state == S_QD);
    div_dividend = dm;
    div_divisor  = a;
    case (state)
      S_EUC: begin
        div_dividend = a;
        div_divisor  = b;
      end
      S_QN: begin
        div_dividend = nm;
      end
      default: begin
        div_dividend = dm;
      end
    endcase
  end

  frd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // Move the sign onto the numerator; a zero quotient stays positive
  assign signed_qn = (neg && (qn != '0)) ? ((~qn) + frd_pkg::WIDTH'(1)) : qn;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= (denominator == '0) ? S_DONE : S_EUC;
          end
        end
        S_EUC: begin
          state <= (b == '0) ? S_QN : S_EUC_WAIT;
        end
        S_EUC_WAIT: begin
          if (div_stat.done) begin
            state <= S_EUC;
          end
        end
        S_QN: begin
          state <= S_QN_WAIT;
        end
        S_QN_WAIT: begin
          if (div_stat.done) begin
            state <= S_QD;
          end
        end
        S_QD: begin
          state <= S_QD_WAIT;
        end
        S_QD_WAIT: begin
          if (div_stat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers: capture the item, then step the Euclid pair and keep the quotient
  always_ff @(posedge clk) begin
    if (in_accept) begin
      num_raw <= $unsigned(numerator);
      nm      <= frd_pkg::magnitude($unsigned(numerator));
      dm      <= frd_pkg::magnitude($unsigned(denominator));
      a       <= frd_pkg::magnitude($unsigned(numerator));
      b       <= frd_pkg::magnitude($unsigned(denominator));
      neg     <= numerator[frd_pkg::WIDTH-1] ^ denominator[frd_pkg::WIDTH-1];
      inv     <= (denominator == '0);
    end else if (div_stat.done && (state == S_EUC_WAIT)) begin
      a <= b;
      b <= div_rem;
    end else if (div_stat.done && (state == S_QN_WAIT)) begin
      qn <= div_quo;
    end
  end

  // Output register: load when the result is ready and the slot is free, drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      if (inv) begin
        reduced_numerator   <= $signed(num_raw);
        reduced_denominator <= '0;
        status              <= 1'b1;
      end else begin
        reduced_numerator   <= $signed(signed_qn);
        reduced_denominator <= $signed(div_quo);
        status              <= 1'b0;
      end
    end
  end

  assign div_waiting = (state == S_EUC_WAIT) || (state == S_QN_WAIT) || (state == S_QD_WAIT);

  // A divider completion only ever arrives while the sequencer waits for it
  `FRD_ASSERT_IMP(a_done_in_wait, div_stat.done, div_waiting)
  // An accepted item always leaves the idle state
  `FRD_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state != S_IDLE)
  // A reduced result never carries a zero denominator
  `FRD_ASSERT_IMP(a_reduced_den_nonzero, out_valid && !status, reduced_denominator != '0)
  // An invalid result always reports a zero denominator
  `FRD_ASSERT_IMP(a_invalid_den_zero, out_valid && status, reduced_denominator == '0)

endmodule
